/* src/sdsh_pkg.sv */
// Package with the phase encoding, command codes and result record of the SD SPI host sequencer.
package sdsh_pkg;

  typedef enum logic [4:0] {
    P_IDLE     = 5'd0,
    P_DUMMY    = 5'd1,
    P_READY    = 5'd2,
    P_SEND     = 5'd3,
    P_R1       = 5'd4,
    P_R7       = 5'd5,
    P_OCR      = 5'd6,
    P_TOKEN    = 5'd7,
    P_DATA     = 5'd8,
    P_RCRC     = 5'd9,
    P_WTOKEN   = 5'd10,
    P_WNEED    = 5'd11,
    P_WDATA    = 5'd12,
    P_WCRC     = 5'd13,
    P_WRESP    = 5'd14,
    P_BUSY     = 5'd15,
    P_BUSYX    = 5'd16,
    W_POWER    = 5'd20,
    W_CMD0     = 5'd21,
    W_CMD8     = 5'd22,
    W_CMD55    = 5'd23,
    W_CMD1     = 5'd24,
    W_CMD1POLL = 5'd25,
    W_BUSYMS   = 5'd26
  } phase_t;

  // Request types.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_WDATA = 2'd3;

  // Operations.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Result kinds.
  localparam logic [1:0] K_XFER = 2'd0;
  localparam logic [1:0] K_READ = 2'd1;
  localparam logic [1:0] K_NEED = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  // Command bytes (start bit and index).
  localparam logic [7:0] C_GO_IDLE  = 8'h40;
  localparam logic [7:0] C_OP_COND  = 8'h41;
  localparam logic [7:0] C_IF_COND  = 8'h48;
  localparam logic [7:0] C_BLOCKLEN = 8'h50;
  localparam logic [7:0] C_READ     = 8'h51;
  localparam logic [7:0] C_WRITE    = 8'h58;
  localparam logic [7:0] C_APP_OP   = 8'h69;
  localparam logic [7:0] C_APP      = 8'h77;
  localparam logic [7:0] C_OCR      = 8'h7a;

  // Card types.
  localparam logic [2:0] T_INVALID = 3'd0;
  localparam logic [2:0] T_SDV1    = 3'd1;
  localparam logic [2:0] T_SDV2    = 3'd2;
  localparam logic [2:0] T_SDHC    = 3'd3;
  localparam logic [2:0] T_MMC     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] R_INIT_RETRY = 3'd0;
  localparam logic [2:0] R_RESP_POLL  = 3'd1;
  localparam logic [2:0] R_TOKEN_TO   = 3'd2;
  localparam logic [2:0] R_BUSY_TO    = 3'd3;
  localparam logic [2:0] R_BUSY_MS    = 3'd4;

  localparam logic [7:0] TOKEN_START = 8'hfe;
  localparam logic [7:0] IDLE_BYTE   = 8'hff;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mosi;
    logic       cs_n;
    logic       fast;
    logic [7:0] rd;
    logic       st;
    logic [2:0] ty;
    logic       lst;
  } res_t;

endpackage

/* src/sd_card_spi_host_sequencer_top.sv */
// Top level of the SD/MMC SPI-mode host sequencer: control state machine and result queue.
//
// Usage: the host side offers one request per cycle on the input channel (in_valid,
// in_stall): a start (initialize, read sector, write sector), the byte the card returned
// on the last transfer, a millisecond tick, or a write data byte. Each request yields
// zero, one or two results on the output channel (out_valid, out_stall): a transfer
// request with the byte to send and chip select and clock speed, a read data byte, a
// request for the next write byte, or operation done with status and card type.
// The field last marks the final result caused by a request.
// Results are registered: a request accepted at a clock edge writes its results into the
// queue at that edge. Throughput is one request per cycle while in_stall is low; the state
// update is a single pass of logic between the state registers. Only a received sector
// data byte yields two results, and the output side then drains them in turn.
// Results go into a four-entry queue. The input channel stalls while more than two
// entries are occupied, so a stalled receiver never loses a result and the input keeps
// flowing as long as the queue drains. Configuration is written through cfg_write,
// cfg_index and cfg_data by the user only while idle; the block does not enforce it.
// Reset (rst, synchronous, active high) empties the queue, returns the sequencer to idle,
// clears the card state and loads the configuration defaults.
module sd_card_spi_host_sequencer_top #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [1:0]  operation,
  input  logic [31:0] sector_address,
  input  logic [7:0]  miso_byte,
  input  logic [7:0]  write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  mosi_byte,
  output logic        chip_select_n,
  output logic        fast_clock,
  output logic [7:0]  read_byte,
  output logic        status,
  output logic [2:0]  card_type,
  output logic        last,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [15:0] SECTOR_COUNT = 16'(SECTOR_BYTES);
  localparam logic [31:0] SECTOR_MUL   = 32'(SECTOR_BYTES);

  // Configuration registers.
  logic [7:0]  init_retry_limit;
  logic [7:0]  response_poll_limit;
  logic [15:0] token_timeout;
  logic [15:0] busy_timeout;
  logic [15:0] busy_extra_ms;

  // Sequencer state.
  sdsh_pkg::phase_t phase, phase_next;
  logic [9:0]  byte_index, byte_index_next;
  logic [15:0] poll_count, poll_count_next;
  logic [7:0]  retry_count, retry_count_next;
  logic [9:0]  wait_ticks, wait_ticks_next;
  logic [47:0] command_frame, command_frame_next;
  logic [7:0]  last_r1, last_r1_next;
  logic [2:0]  detected_type, detected_type_next;
  logic        high_capacity, high_capacity_next;
  logic        fast_mode, fast_mode_next;
  logic [31:0] byte_address, byte_address_next;

  // Result queue.
  sdsh_pkg::res_t queue [4];
  logic [1:0] head, tail;
  logic [2:0] count;

  logic accept, pop;
  logic [1:0] nres;
  sdsh_pkg::res_t res_a, res_b;

  function automatic logic [7:0] al1_8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [15:0] al1_16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [47:0] f, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0: b = f[47:40];
      3'd1: b = f[39:32];
      3'd2: b = f[31:24];
      3'd3: b = f[23:16];
      3'd4: b = f[15:8];
      3'd5: b = f[7:0];
      default: b = f[47:40];
    endcase
    return b;
  endfunction

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;
  assign in_stall  = (count > 3'd2);
  assign out_valid = (count != 3'd0);

  // Next-state logic. Each path ends in at most one terminal action (wait, issue,
  // finish or transfer), applied in a common tail so the pieces stay short.
  always_comb begin
    logic [7:0]  cmd;
    logic [7:0]  m;
    logic [15:0] lim;
    logic [15:0] poll_inc;
    logic [7:0]  rc_inc;
    logic        do_wait, do_issue, do_finish, do_xfer, do_need, do_read, do_bad_op;
    logic        iss_ready, fin_status;
    sdsh_pkg::phase_t wait_ph;
    logic [9:0]  wait_n;
    logic [7:0]  iss_cmd, iss_crc, xfer_byte;
    logic [31:0] iss_arg;
    logic        r1_path, r1_tmo, end_acmd, post_op;

    phase_next         = phase;
    byte_index_next    = byte_index;
    poll_count_next    = poll_count;
    retry_count_next   = retry_count;
    wait_ticks_next    = wait_ticks;
    command_frame_next = command_frame;
    last_r1_next       = last_r1;
    detected_type_next = detected_type;
    high_capacity_next = high_capacity;
    fast_mode_next     = fast_mode;
    byte_address_next  = byte_address;

    cmd      = command_frame[47:40];
    m        = miso_byte;
    poll_inc = poll_count + 16'd1;
    rc_inc   = retry_count + 8'd1;
    lim      = (cmd == sdsh_pkg::C_WRITE) ? al1_16(busy_timeout)
                                          : {8'd0, al1_8(response_poll_limit)};
    do_wait = 1'b0; do_issue = 1'b0; do_finish = 1'b0; do_xfer = 1'b0;
    do_need = 1'b0; do_read = 1'b0; do_bad_op = 1'b0;
    iss_ready = 1'b1; fin_status = 1'b0;
    wait_ph = sdsh_pkg::P_IDLE; wait_n = 10'd0;
    iss_cmd = 8'd0; iss_crc = sdsh_pkg::IDLE_BYTE; iss_arg = 32'd0;
    xfer_byte = sdsh_pkg::IDLE_BYTE;
    r1_path = 1'b0; r1_tmo = 1'b0; end_acmd = 1'b0; post_op = 1'b0;

    if (accept) begin
      case (req_type)
        sdsh_pkg::REQ_START: begin
          if (operation == sdsh_pkg::OP_INIT) begin
            high_capacity_next = 1'b0;
            fast_mode_next     = 1'b0;
            detected_type_next = sdsh_pkg::T_INVALID;
            command_frame_next = 48'd0;
            retry_count_next   = 8'd0;
            last_r1_next       = 8'h80;
            byte_index_next    = 10'd0;
            phase_next         = sdsh_pkg::P_DUMMY;
            do_xfer            = 1'b1;
          end else if (operation == sdsh_pkg::OP_READ || operation == sdsh_pkg::OP_WRITE) begin
            byte_address_next = high_capacity ? sector_address
                                              : 32'(sector_address * SECTOR_MUL);
            do_issue = 1'b1;
            iss_cmd  = (operation == sdsh_pkg::OP_READ) ? sdsh_pkg::C_READ
                                                        : sdsh_pkg::C_WRITE;
            iss_arg  = byte_address_next;
          end else begin
            phase_next = sdsh_pkg::P_IDLE;
            do_bad_op  = 1'b1;
          end
        end
        sdsh_pkg::REQ_BYTE: begin
          case (phase)
            sdsh_pkg::P_DUMMY: begin
              byte_index_next = byte_index + 10'd1;
              if (byte_index_next < 10'd10) do_xfer = 1'b1;
              else begin
                do_wait = 1'b1; wait_ph = sdsh_pkg::W_POWER; wait_n = 10'd100;
              end
            end
            sdsh_pkg::P_READY: begin
              if (m == 8'hff) begin
                phase_next = sdsh_pkg::P_SEND; byte_index_next = 10'd1;
                xfer_byte = cmd;
              end
              do_xfer = 1'b1;
            end
            sdsh_pkg::P_SEND: begin
              if (byte_index < 10'd6) begin
                xfer_byte = frame_byte(command_frame, byte_index[2:0]);
                byte_index_next = byte_index + 10'd1;
                do_xfer = 1'b1;
              end else begin
                poll_count_next = 16'd0;
                if (cmd == sdsh_pkg::C_OP_COND) begin
                  do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD1POLL; wait_n = 10'd10;
                end else begin
                  phase_next = sdsh_pkg::P_R1; do_xfer = 1'b1;
                end
              end
            end
            sdsh_pkg::P_R1: begin
              poll_count_next = poll_inc;
              if (!m[7]) r1_path = 1'b1;
              else if (poll_inc >= lim) r1_tmo = 1'b1;
              else if (cmd == sdsh_pkg::C_OP_COND) begin
                do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD1POLL; wait_n = 10'd10;
              end else do_xfer = 1'b1;
            end
            sdsh_pkg::P_R7: begin
              byte_index_next = byte_index + 10'd1;
              if (byte_index_next < 10'd4) do_xfer = 1'b1;
              else begin
                detected_type_next = last_r1[2] ? sdsh_pkg::T_SDV1 : sdsh_pkg::T_SDV2;
                retry_count_next = 8'd0;
                do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD55; wait_n = 10'd20;
              end
            end
            sdsh_pkg::P_OCR: begin
              if (byte_index == 10'd0 && m[6]) begin
                high_capacity_next = 1'b1;
                detected_type_next = sdsh_pkg::T_SDHC;
              end
              byte_index_next = byte_index + 10'd1;
              if (byte_index_next < 10'd4) do_xfer = 1'b1;
              else begin
                fast_mode_next = 1'b1;
                do_issue = 1'b1; iss_cmd = sdsh_pkg::C_BLOCKLEN;
                iss_arg = SECTOR_MUL;
              end
            end
            sdsh_pkg::P_TOKEN: begin
              poll_count_next = poll_inc;
              if (m == sdsh_pkg::TOKEN_START) begin
                poll_count_next = 16'd0; phase_next = sdsh_pkg::P_DATA; do_xfer = 1'b1;
              end else if (m[7:4] == 4'd0) begin
                do_finish = 1'b1; fin_status = 1'b1;
              end else if (poll_inc >= al1_16(token_timeout)) begin
                do_finish = 1'b1; fin_status = 1'b1;
              end else do_xfer = 1'b1;
            end
            sdsh_pkg::P_DATA: begin
              do_read = 1'b1;
              do_xfer = 1'b1;
              poll_count_next = poll_inc;
              if (poll_inc >= SECTOR_COUNT) begin
                byte_index_next = 10'd0; phase_next = sdsh_pkg::P_RCRC;
              end
            end
            sdsh_pkg::P_RCRC: begin
              byte_index_next = byte_index + 10'd1;
              if (byte_index_next < 10'd2) do_xfer = 1'b1;
              else do_finish = 1'b1;
            end
            sdsh_pkg::P_WTOKEN: begin
              poll_count_next = 16'd0; phase_next = sdsh_pkg::P_WNEED; do_need = 1'b1;
            end
            sdsh_pkg::P_WDATA: begin
              poll_count_next = poll_inc;
              if (poll_inc < SECTOR_COUNT) begin
                phase_next = sdsh_pkg::P_WNEED; do_need = 1'b1;
              end else begin
                byte_index_next = 10'd0; phase_next = sdsh_pkg::P_WCRC; do_xfer = 1'b1;
              end
            end
            sdsh_pkg::P_WCRC: begin
              byte_index_next = byte_index + 10'd1;
              if (byte_index_next >= 10'd2) begin
                poll_count_next = 16'd0; phase_next = sdsh_pkg::P_WRESP;
              end
              do_xfer = 1'b1;
            end
            sdsh_pkg::P_WRESP: begin
              poll_count_next = poll_inc;
              if (!m[4] || poll_inc >= {8'd0, al1_8(response_poll_limit)}) begin
                if (m[4:0] == 5'h05) begin
                  poll_count_next = 16'd0; phase_next = sdsh_pkg::P_BUSY; do_xfer = 1'b1;
                end else begin
                  do_finish = 1'b1; fin_status = 1'b1;
                end
              end else do_xfer = 1'b1;
            end
            sdsh_pkg::P_BUSY: begin
              poll_count_next = poll_inc;
              if (m == 8'hff) do_finish = 1'b1;
              else if (poll_inc >= al1_16(busy_timeout)) begin
                if (busy_extra_ms == 16'd0) begin
                  do_finish = 1'b1; fin_status = 1'b1;
                end else begin
                  poll_count_next = 16'd0;
                  do_wait = 1'b1; wait_ph = sdsh_pkg::W_BUSYMS; wait_n = 10'd1;
                end
              end else do_xfer = 1'b1;
            end
            sdsh_pkg::P_BUSYX: begin
              poll_count_next = poll_inc;
              if (m == 8'hff) do_finish = 1'b1;
              else if (poll_inc >= busy_extra_ms) begin
                do_finish = 1'b1; fin_status = 1'b1;
              end else begin
                do_wait = 1'b1; wait_ph = sdsh_pkg::W_BUSYMS; wait_n = 10'd1;
              end
            end
            default: ;
          endcase
        end
        sdsh_pkg::REQ_TICK: begin
          if (phase inside {[sdsh_pkg::W_POWER:sdsh_pkg::W_BUSYMS]}) begin
            if (wait_ticks > 10'd1) wait_ticks_next = wait_ticks - 10'd1;
            else begin
              wait_ticks_next = 10'd0;
              case (phase)
                sdsh_pkg::W_POWER: begin
                  retry_count_next = 8'd0;
                  do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD0; wait_n = 10'd20;
                end
                sdsh_pkg::W_CMD0: begin
                  do_issue = 1'b1; iss_cmd = sdsh_pkg::C_GO_IDLE;
                  iss_crc = 8'h95; iss_ready = 1'b0;
                end
                sdsh_pkg::W_CMD8: begin
                  do_issue = 1'b1; iss_cmd = sdsh_pkg::C_IF_COND;
                  iss_arg = 32'h1aa; iss_crc = 8'h87;
                end
                sdsh_pkg::W_CMD55: begin
                  do_issue = 1'b1; iss_cmd = sdsh_pkg::C_APP;
                end
                sdsh_pkg::W_CMD1: begin
                  do_issue = 1'b1; iss_cmd = sdsh_pkg::C_OP_COND;
                end
                sdsh_pkg::W_CMD1POLL: begin
                  phase_next = sdsh_pkg::P_R1; do_xfer = 1'b1;
                end
                default: begin
                  phase_next = sdsh_pkg::P_BUSYX; do_xfer = 1'b1;
                end
              endcase
            end
          end
        end
        default: begin
          if (phase == sdsh_pkg::P_WNEED) begin
            phase_next = sdsh_pkg::P_WDATA; xfer_byte = write_byte; do_xfer = 1'b1;
          end
        end
      endcase
    end

    // R1 received: dispatch on the command that is in flight.
    if (r1_path) begin
      last_r1_next = m;
      case (cmd)
        sdsh_pkg::C_GO_IDLE: begin
          do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD8; wait_n = 10'd20;
        end
        sdsh_pkg::C_IF_COND: begin
          byte_index_next = 10'd0; phase_next = sdsh_pkg::P_R7; do_xfer = 1'b1;
        end
        sdsh_pkg::C_APP: begin
          do_issue = 1'b1; iss_cmd = sdsh_pkg::C_APP_OP;
          iss_arg = (detected_type == sdsh_pkg::T_SDV2) ? 32'h4000_0000 : 32'd0;
        end
        sdsh_pkg::C_APP_OP: begin
          retry_count_next = rc_inc;
          if (detected_type == sdsh_pkg::T_SDV1 && rc_inc == 8'd1 && m[2]) end_acmd = 1'b1;
          else if (m[0] && rc_inc < al1_8(init_retry_limit)) begin
            do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD55; wait_n = 10'd20;
          end else end_acmd = 1'b1;
        end
        sdsh_pkg::C_OP_COND: begin
          retry_count_next = rc_inc;
          if (m[0] && rc_inc < al1_8(init_retry_limit)) begin
            do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD1; wait_n = 10'd10;
          end else post_op = 1'b1;
        end
        sdsh_pkg::C_OCR: begin
          byte_index_next = 10'd0; phase_next = sdsh_pkg::P_OCR; do_xfer = 1'b1;
        end
        sdsh_pkg::C_BLOCKLEN: do_finish = 1'b1;
        sdsh_pkg::C_READ: begin
          poll_count_next = 16'd0; phase_next = sdsh_pkg::P_TOKEN; do_xfer = 1'b1;
        end
        sdsh_pkg::C_WRITE: begin
          if (m != 8'd0) begin
            do_finish = 1'b1; fin_status = 1'b1;
          end else begin
            phase_next = sdsh_pkg::P_WTOKEN; xfer_byte = sdsh_pkg::TOKEN_START;
            do_xfer = 1'b1;
          end
        end
        default: begin
          do_finish = 1'b1; fin_status = 1'b1;
        end
      endcase
    end

    // An illegal-command response during the ACMD41 loop means an MMC card.
    if (end_acmd) begin
      if (m[2]) begin
        detected_type_next = sdsh_pkg::T_MMC; retry_count_next = 8'd0;
        do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD1; wait_n = 10'd10;
      end else post_op = 1'b1;
    end

    if (post_op) begin
      if (m[0]) begin
        do_finish = 1'b1; fin_status = 1'b1;
      end else if (detected_type == sdsh_pkg::T_SDV2) begin
        do_issue = 1'b1; iss_cmd = sdsh_pkg::C_OCR;
      end else begin
        fast_mode_next = 1'b1;
        do_issue = 1'b1; iss_cmd = sdsh_pkg::C_BLOCKLEN; iss_arg = SECTOR_MUL;
      end
    end

    // No R1 within the poll limit: CMD0 is retried, a SET_BLOCKLEN timeout still passes.
    if (r1_tmo) begin
      if (cmd == sdsh_pkg::C_GO_IDLE) begin
        retry_count_next = rc_inc;
        if (rc_inc < al1_8(init_retry_limit)) begin
          do_wait = 1'b1; wait_ph = sdsh_pkg::W_CMD0; wait_n = 10'd20;
        end else begin
          do_finish = 1'b1; fin_status = 1'b1;
        end
      end else if (cmd == sdsh_pkg::C_BLOCKLEN) do_finish = 1'b1;
      else begin
        do_finish = 1'b1; fin_status = 1'b1;
      end
    end

    if (do_wait) begin
      phase_next = wait_ph; wait_ticks_next = wait_n;
    end

    if (do_issue) begin
      command_frame_next = {iss_cmd, iss_arg, iss_crc};
      do_xfer = 1'b1;
      if (iss_ready) begin
        phase_next = sdsh_pkg::P_READY; xfer_byte = sdsh_pkg::IDLE_BYTE;
      end else begin
        phase_next = sdsh_pkg::P_SEND; byte_index_next = 10'd1; xfer_byte = iss_cmd;
      end
    end

    // A failed start-up forgets the card; a failed read or write keeps it.
    if (do_finish) begin
      phase_next = sdsh_pkg::P_IDLE;
      if (fin_status && cmd != sdsh_pkg::C_READ && cmd != sdsh_pkg::C_WRITE) begin
        detected_type_next = sdsh_pkg::T_INVALID; high_capacity_next = 1'b0;
      end
    end

    // Result assembly.
    res_a = '0;
    res_b = '0;
    nres  = 2'd0;
    if (do_read) begin
      res_a.kind = sdsh_pkg::K_READ; res_a.rd = m;
      res_b.kind = sdsh_pkg::K_XFER; res_b.mosi = sdsh_pkg::IDLE_BYTE;
      res_b.cs_n = (phase_next == sdsh_pkg::P_DUMMY); res_b.fast = fast_mode_next;
      res_b.lst  = 1'b1;
      nres = 2'd2;
    end else if (do_xfer) begin
      res_a.kind = sdsh_pkg::K_XFER; res_a.mosi = xfer_byte;
      res_a.cs_n = (phase_next == sdsh_pkg::P_DUMMY); res_a.fast = fast_mode_next;
      res_a.lst  = 1'b1;
      nres = 2'd1;
    end else if (do_finish || do_bad_op) begin
      res_a.kind = sdsh_pkg::K_DONE; res_a.st = fin_status || do_bad_op;
      res_a.ty = detected_type_next; res_a.lst = 1'b1;
      nres = 2'd1;
    end else if (do_need) begin
      res_a.kind = sdsh_pkg::K_NEED; res_a.lst = 1'b1;
      nres = 2'd1;
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdsh_pkg::P_IDLE;
      byte_index    <= 10'd0;
      poll_count    <= 16'd0;
      retry_count   <= 8'd0;
      wait_ticks    <= 10'd0;
      command_frame <= 48'd0;
      last_r1       <= 8'h80;
      detected_type <= sdsh_pkg::T_INVALID;
      high_capacity <= 1'b0;
      fast_mode     <= 1'b0;
      byte_address  <= 32'd0;
    end else begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      poll_count    <= poll_count_next;
      retry_count   <= retry_count_next;
      wait_ticks    <= wait_ticks_next;
      command_frame <= command_frame_next;
      last_r1       <= last_r1_next;
      detected_type <= detected_type_next;
      high_capacity <= high_capacity_next;
      fast_mode     <= fast_mode_next;
      byte_address  <= byte_address_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_retry_limit    <= 8'd200;
      response_poll_limit <= 8'd255;
      token_timeout       <= 16'd20000;
      busy_timeout        <= 16'd30000;
      busy_extra_ms       <= 16'd1000;
    end else if (cfg_write) begin
      case (cfg_index)
        sdsh_pkg::R_INIT_RETRY: init_retry_limit    <= cfg_data[7:0];
        sdsh_pkg::R_RESP_POLL:  response_poll_limit <= cfg_data[7:0];
        sdsh_pkg::R_TOKEN_TO:   token_timeout       <= cfg_data;
        sdsh_pkg::R_BUSY_TO:    busy_timeout        <= cfg_data;
        sdsh_pkg::R_BUSY_MS:    busy_extra_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result queue: up to two writes per accepted request, one read per unstalled cycle.
  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) queue[tail] <= res_a;
    if (accept && nres == 2'd2) queue[tail + 2'd1] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (accept) tail <= tail + nres;
      if (pop) head <= head + 2'd1;
      count <= count + (accept ? {1'b0, nres} : 3'd0) - {2'd0, pop};
    end
  end

  assign out_kind      = queue[head].kind;
  assign mosi_byte     = queue[head].mosi;
  assign chip_select_n = queue[head].cs_n;
  assign fast_clock    = queue[head].fast;
  assign read_byte     = queue[head].rd;
  assign status        = queue[head].st;
  assign card_type     = queue[head].ty;
  assign last          = queue[head].lst;

endmodule

/* verif/sd_card_spi_host_sequencer_top_tb.sv */
// Self-checking testbench for the SD/MMC SPI-mode host sequencer with a reactive card model.
module sd_card_spi_host_sequencer_top_tb;

  localparam int SECTOR = 512;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 20;
  // Operation code with no meaning, answered by done with an error status.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One request with the results the card predictor expects from it.
  typedef struct {
    logic [1:0]      req;
    logic [1:0]      op;
    logic [31:0]     sector;
    logic [7:0]      miso;
    logic [7:0]      wbyte;
    int              n;
    sdsh_pkg::res_t  r0;
    sdsh_pkg::res_t  r1;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = sdsh_pkg::REQ_TICK;
  logic [1:0] operation = sdsh_pkg::OP_INIT;
  logic [31:0] sector_address = '0;
  logic [7:0] miso_byte = '0;
  logic [7:0] write_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] mosi_byte;
  logic chip_select_n;
  logic fast_clock;
  logic [7:0] read_byte;
  logic status;
  logic [2:0] card_type;
  logic last;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sd_card_spi_host_sequencer_top #(.SECTOR_BYTES(SECTOR)) i_dut (.*);

  always #1 clk = ~clk;

  // Requests waiting to be offered, and results still owed by the block.
  request_t pending_reqs[$];
  sdsh_pkg::res_t owed_results[$];
  request_t cur_req;
  int mismatches = 0;
  int sender_idle_pct = 15;
  int receiver_stall_pct = 69;
  int cycles = 0;
  // Requests generated so far; each section of the run stops at a running total.
  int generated = 0;

  // Shadow copy of the sequencer state, advanced when a request is generated. Since
  // requests are accepted in order, this matches the block at acceptance time.
  sdsh_pkg::phase_t ph;
  logic [9:0]  bidx;
  logic [15:0] polls;
  logic [7:0]  retries;
  logic [9:0]  ticks_left;
  logic [47:0] frame;
  logic [7:0]  r1_seen;
  logic [2:0]  ctype;
  logic        hcap;
  logic        fastm;
  logic [31:0] baddr;
  logic [7:0]  lim_retry;
  logic [7:0]  lim_resp;
  logic [15:0] lim_token;
  logic [15:0] lim_busy;
  logic [15:0] extra_ms;
  sdsh_pkg::res_t rbuf[2];
  int          nres;

  function automatic logic [15:0] at_least_one(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic void put_result(logic [1:0] k, logic [7:0] m, logic cs, logic f,
                                     logic [7:0] rd, logic st, logic [2:0] ty);
    if (nres < 2) begin
      rbuf[nres] = '{kind: k, mosi: m, cs_n: cs, fast: f, rd: rd, st: st, ty: ty, lst: 1'b0};
      nres++;
    end
  endfunction

  function automatic void transfer(logic [7:0] m);
    put_result(sdsh_pkg::K_XFER, m, ph == sdsh_pkg::P_DUMMY, fastm, 8'd0, 1'b0,
               sdsh_pkg::T_INVALID);
  endfunction

  function automatic logic [7:0] frame_at(int k);
    return 8'(frame >> ((5 - (k % 6)) * 8));
  endfunction

  function automatic void start_wait(sdsh_pkg::phase_t p, logic [9:0] n);
    ph = p;
    ticks_left = n;
  endfunction

  function automatic void send_cmd(logic [7:0] cmd, logic [31:0] arg, logic [7:0] crc,
                                   logic ready);
    frame = {cmd, arg, crc};
    if (ready) begin
      ph = sdsh_pkg::P_READY;
      transfer(sdsh_pkg::IDLE_BYTE);
    end else begin
      ph = sdsh_pkg::P_SEND;
      bidx = 10'd1;
      transfer(cmd);
    end
  endfunction

  function automatic void op_done(logic st);
    logic [7:0] cmd;
    cmd = frame_at(0);
    ph = sdsh_pkg::P_IDLE;
    // Failed start-up forgets the card; failed reads and writes keep it.
    if (st && cmd != sdsh_pkg::C_READ && cmd != sdsh_pkg::C_WRITE) begin
      ctype = sdsh_pkg::T_INVALID;
      hcap = 1'b0;
    end
    put_result(sdsh_pkg::K_DONE, 8'd0, 1'b0, 1'b0, 8'd0, st, ctype);
  endfunction

  function automatic void after_opcond(logic [7:0] r);
    if (r[0]) op_done(1'b1);
    else if (ctype == sdsh_pkg::T_SDV2) send_cmd(sdsh_pkg::C_OCR, 32'd0, 8'hff, 1'b1);
    else begin
      fastm = 1'b1;
      send_cmd(sdsh_pkg::C_BLOCKLEN, 32'(SECTOR), 8'hff, 1'b1);
    end
  endfunction

  function automatic void leave_acmd(logic [7:0] r);
    // An illegal-command bit here means an MMC card: fall back to CMD1.
    if (r[2]) begin
      ctype = sdsh_pkg::T_MMC;
      retries = 8'd0;
      start_wait(sdsh_pkg::W_CMD1, 10'd10);
    end else after_opcond(r);
  endfunction

  function automatic void got_r1(logic [7:0] r);
    logic [7:0] cmd;
    cmd = frame_at(0);
    r1_seen = r;
    case (cmd)
      sdsh_pkg::C_GO_IDLE: start_wait(sdsh_pkg::W_CMD8, 10'd20);
      sdsh_pkg::C_IF_COND: begin
        bidx = 10'd0;
        ph = sdsh_pkg::P_R7;
        transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::C_APP: send_cmd(sdsh_pkg::C_APP_OP,
                                (ctype == sdsh_pkg::T_SDV2) ? 32'h4000_0000 : 32'd0,
                                8'hff, 1'b1);
      sdsh_pkg::C_APP_OP: begin
        retries++;
        if (ctype == sdsh_pkg::T_SDV1 && retries == 8'd1 && r[2]) leave_acmd(r);
        else if (r[0] && retries < at_least_one({8'd0, lim_retry}))
          start_wait(sdsh_pkg::W_CMD55, 10'd20);
        else leave_acmd(r);
      end
      sdsh_pkg::C_OP_COND: begin
        retries++;
        if (r[0] && retries < at_least_one({8'd0, lim_retry}))
          start_wait(sdsh_pkg::W_CMD1, 10'd10);
        else after_opcond(r);
      end
      sdsh_pkg::C_OCR: begin
        bidx = 10'd0;
        ph = sdsh_pkg::P_OCR;
        transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::C_BLOCKLEN: op_done(1'b0);
      sdsh_pkg::C_READ: begin
        polls = 16'd0;
        ph = sdsh_pkg::P_TOKEN;
        transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::C_WRITE: begin
        if (r != 8'd0) op_done(1'b1);
        else begin
          ph = sdsh_pkg::P_WTOKEN;
          transfer(sdsh_pkg::TOKEN_START);
        end
      end
      default: op_done(1'b1);
    endcase
  endfunction

  function automatic void r1_timed_out();
    logic [7:0] cmd;
    cmd = frame_at(0);
    if (cmd == sdsh_pkg::C_GO_IDLE) begin
      retries++;
      if (retries < at_least_one({8'd0, lim_retry})) start_wait(sdsh_pkg::W_CMD0, 10'd20);
      else op_done(1'b1);
    end else if (cmd == sdsh_pkg::C_BLOCKLEN) op_done(1'b0);
    else op_done(1'b1);
  endfunction

  function automatic void card_byte(logic [7:0] m);
    logic [7:0] cmd;
    logic [15:0] lim;
    cmd = frame_at(0);
    case (ph)
      sdsh_pkg::P_DUMMY: begin
        bidx++;
        if (bidx < 10'd10) transfer(sdsh_pkg::IDLE_BYTE);
        else start_wait(sdsh_pkg::W_POWER, 10'd100);
      end
      sdsh_pkg::P_READY: begin
        if (m == sdsh_pkg::IDLE_BYTE) begin
          ph = sdsh_pkg::P_SEND;
          bidx = 10'd1;
          transfer(cmd);
        end else transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::P_SEND: begin
        if (bidx < 10'd6) begin
          transfer(frame_at(int'(bidx)));
          bidx++;
        end else begin
          polls = 16'd0;
          if (cmd == sdsh_pkg::C_OP_COND) start_wait(sdsh_pkg::W_CMD1POLL, 10'd10);
          else begin
            ph = sdsh_pkg::P_R1;
            transfer(sdsh_pkg::IDLE_BYTE);
          end
        end
      end
      sdsh_pkg::P_R1: begin
        polls++;
        lim = at_least_one((cmd == sdsh_pkg::C_WRITE) ? lim_busy : {8'd0, lim_resp});
        if (!m[7]) got_r1(m);
        else if (polls >= lim) r1_timed_out();
        else if (cmd == sdsh_pkg::C_OP_COND) start_wait(sdsh_pkg::W_CMD1POLL, 10'd10);
        else transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::P_R7: begin
        bidx++;
        if (bidx < 10'd4) transfer(sdsh_pkg::IDLE_BYTE);
        else begin
          ctype = r1_seen[2] ? sdsh_pkg::T_SDV1 : sdsh_pkg::T_SDV2;
          retries = 8'd0;
          start_wait(sdsh_pkg::W_CMD55, 10'd20);
        end
      end
      sdsh_pkg::P_OCR: begin
        if (bidx == 10'd0 && m[6]) begin
          hcap = 1'b1;
          ctype = sdsh_pkg::T_SDHC;
        end
        bidx++;
        if (bidx < 10'd4) transfer(sdsh_pkg::IDLE_BYTE);
        else begin
          fastm = 1'b1;
          send_cmd(sdsh_pkg::C_BLOCKLEN, 32'(SECTOR), 8'hff, 1'b1);
        end
      end
      sdsh_pkg::P_TOKEN: begin
        polls++;
        if (m == sdsh_pkg::TOKEN_START) begin
          polls = 16'd0;
          ph = sdsh_pkg::P_DATA;
          transfer(sdsh_pkg::IDLE_BYTE);
        end else if (m[7:4] == 4'd0) op_done(1'b1);
        else if (polls >= at_least_one(lim_token)) op_done(1'b1);
        else transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::P_DATA: begin
        put_result(sdsh_pkg::K_READ, 8'd0, 1'b0, 1'b0, m, 1'b0, sdsh_pkg::T_INVALID);
        polls++;
        if (polls < 16'(SECTOR)) transfer(sdsh_pkg::IDLE_BYTE);
        else begin
          bidx = 10'd0;
          ph = sdsh_pkg::P_RCRC;
          transfer(sdsh_pkg::IDLE_BYTE);
        end
      end
      sdsh_pkg::P_RCRC: begin
        bidx++;
        if (bidx < 10'd2) transfer(sdsh_pkg::IDLE_BYTE);
        else op_done(1'b0);
      end
      sdsh_pkg::P_WTOKEN: begin
        polls = 16'd0;
        ph = sdsh_pkg::P_WNEED;
        put_result(sdsh_pkg::K_NEED, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, sdsh_pkg::T_INVALID);
      end
      sdsh_pkg::P_WDATA: begin
        polls++;
        if (polls < 16'(SECTOR)) begin
          ph = sdsh_pkg::P_WNEED;
          put_result(sdsh_pkg::K_NEED, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, sdsh_pkg::T_INVALID);
        end else begin
          bidx = 10'd0;
          ph = sdsh_pkg::P_WCRC;
          transfer(sdsh_pkg::IDLE_BYTE);
        end
      end
      sdsh_pkg::P_WCRC: begin
        bidx++;
        if (bidx < 10'd2) transfer(sdsh_pkg::IDLE_BYTE);
        else begin
          polls = 16'd0;
          ph = sdsh_pkg::P_WRESP;
          transfer(sdsh_pkg::IDLE_BYTE);
        end
      end
      sdsh_pkg::P_WRESP: begin
        polls++;
        if (!m[4] || polls >= at_least_one({8'd0, lim_resp})) begin
          if (m[4:0] == 5'h05) begin
            polls = 16'd0;
            ph = sdsh_pkg::P_BUSY;
            transfer(sdsh_pkg::IDLE_BYTE);
          end else op_done(1'b1);
        end else transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::P_BUSY: begin
        polls++;
        if (m == sdsh_pkg::IDLE_BYTE) op_done(1'b0);
        else if (polls >= at_least_one(lim_busy)) begin
          if (extra_ms == 16'd0) op_done(1'b1);
          else begin
            polls = 16'd0;
            start_wait(sdsh_pkg::W_BUSYMS, 10'd1);
          end
        end else transfer(sdsh_pkg::IDLE_BYTE);
      end
      sdsh_pkg::P_BUSYX: begin
        polls++;
        if (m == sdsh_pkg::IDLE_BYTE) op_done(1'b0);
        else if (polls >= extra_ms) op_done(1'b1);
        else start_wait(sdsh_pkg::W_BUSYMS, 10'd1);
      end
      default: ;
    endcase
  endfunction

  function automatic void card_tick();
    if (ph < sdsh_pkg::W_POWER || ph > sdsh_pkg::W_BUSYMS) return;
    if (ticks_left > 10'd1) begin
      ticks_left--;
      return;
    end
    ticks_left = 10'd0;
    case (ph)
      sdsh_pkg::W_POWER: begin
        retries = 8'd0;
        start_wait(sdsh_pkg::W_CMD0, 10'd20);
      end
      sdsh_pkg::W_CMD0: send_cmd(sdsh_pkg::C_GO_IDLE, 32'd0, 8'h95, 1'b0);
      sdsh_pkg::W_CMD8: send_cmd(sdsh_pkg::C_IF_COND, 32'h1aa, 8'h87, 1'b1);
      sdsh_pkg::W_CMD55: send_cmd(sdsh_pkg::C_APP, 32'd0, 8'hff, 1'b1);
      sdsh_pkg::W_CMD1: send_cmd(sdsh_pkg::C_OP_COND, 32'd0, 8'hff, 1'b1);
      sdsh_pkg::W_CMD1POLL: begin
        ph = sdsh_pkg::P_R1;
        transfer(sdsh_pkg::IDLE_BYTE);
      end
      default: begin
        ph = sdsh_pkg::P_BUSYX;
        transfer(sdsh_pkg::IDLE_BYTE);
      end
    endcase
  endfunction

  function automatic void card_start(logic [1:0] op, logic [31:0] sec);
    if (op == sdsh_pkg::OP_INIT) begin
      hcap = 1'b0;
      fastm = 1'b0;
      ctype = sdsh_pkg::T_INVALID;
      frame = '0;
      retries = 8'd0;
      r1_seen = 8'h80;
      bidx = 10'd0;
      ph = sdsh_pkg::P_DUMMY;
      transfer(sdsh_pkg::IDLE_BYTE);
    end else if (op == sdsh_pkg::OP_READ || op == sdsh_pkg::OP_WRITE) begin
      // Standard-capacity cards take byte addresses.
      baddr = hcap ? sec : 32'(sec * 32'(SECTOR));
      send_cmd((op == sdsh_pkg::OP_READ) ? sdsh_pkg::C_READ : sdsh_pkg::C_WRITE, baddr,
               8'hff, 1'b1);
    end else begin
      ph = sdsh_pkg::P_IDLE;
      put_result(sdsh_pkg::K_DONE, 8'd0, 1'b0, 1'b0, 8'd0, 1'b1, ctype);
    end
  endfunction

  // Predicts one request's results and queues it for the driver.
  function automatic void queue_request(logic [1:0] rq, logic [1:0] op, logic [31:0] sec,
                                        logic [7:0] m, logic [7:0] wb);
    request_t r;
    nres = 0;
    case (rq)
      sdsh_pkg::REQ_START: card_start(op, sec);
      sdsh_pkg::REQ_BYTE: card_byte(m);
      sdsh_pkg::REQ_TICK: card_tick();
      default: begin
        if (ph == sdsh_pkg::P_WNEED) begin
          ph = sdsh_pkg::P_WDATA;
          transfer(wb);
        end
      end
    endcase
    if (nres > 0) rbuf[nres - 1].lst = 1'b1;
    r.req = rq;
    r.op = op;
    r.sector = sec;
    r.miso = m;
    r.wbyte = wb;
    r.n = nres;
    r.r0 = rbuf[0];
    r.r1 = rbuf[1];
    pending_reqs.push_back(r);
    generated++;
  endfunction

  // The byte a plausible card returns in the current phase, with occasional faults.
  function automatic logic [7:0] card_reply();
    logic [7:0] rnd;
    logic [7:0] cmd;
    rnd = 8'($urandom);
    cmd = frame_at(0);
    case (ph)
      sdsh_pkg::P_READY: return ($urandom_range(0, 9) != 0) ? sdsh_pkg::IDLE_BYTE : rnd;
      sdsh_pkg::P_R1: begin
        if ($urandom_range(0, 5) == 0) return rnd | 8'h80;
        case (cmd)
          sdsh_pkg::C_GO_IDLE, sdsh_pkg::C_APP: return 8'h01;
          sdsh_pkg::C_IF_COND: return ($urandom_range(0, 2) == 0) ? 8'h05 : 8'h01;
          sdsh_pkg::C_APP_OP, sdsh_pkg::C_OP_COND: begin
            case ($urandom_range(0, 5))
              0, 1: return 8'h01;
              2: return 8'h05;
              3: return rnd & 8'h7f;
              default: return 8'h00;
            endcase
          end
          default: return ($urandom_range(0, 7) == 0) ? (rnd & 8'h7f) : 8'h00;
        endcase
      end
      sdsh_pkg::P_TOKEN: return ($urandom_range(0, 2) != 0) ? sdsh_pkg::TOKEN_START : rnd;
      sdsh_pkg::P_WRESP: return ($urandom_range(0, 3) != 0) ? 8'he5 : rnd;
      sdsh_pkg::P_BUSY, sdsh_pkg::P_BUSYX:
        return ($urandom_range(0, 3) == 0) ? sdsh_pkg::IDLE_BYTE : (rnd & 8'hfe);
      default: return rnd;
    endcase
  endfunction

  // Runs one operation against the card model until it is done, the request total reaches
  // stop_at, the step limit is hit or a random break ends it. An operation cut short is
  // left running, so the next start abandons it.
  task automatic run_op(logic [1:0] op, logic [31:0] sec, int stop_at);
    int steps;
    steps = 0;
    queue_request(sdsh_pkg::REQ_START, op, sec, 8'($urandom), 8'($urandom));
    while (ph != sdsh_pkg::P_IDLE && steps < 4000 && generated < stop_at) begin
      steps++;
      if ($urandom_range(0, 999) == 0) break;
      if ($urandom_range(0, 24) == 0)
        queue_request(2'($urandom_range(sdsh_pkg::REQ_BYTE, sdsh_pkg::REQ_WDATA)),
                      2'($urandom), $urandom, 8'($urandom), 8'($urandom));
      else if (ph >= sdsh_pkg::W_POWER)
        queue_request(sdsh_pkg::REQ_TICK, sdsh_pkg::OP_INIT, 32'd0, 8'($urandom),
                      8'($urandom));
      else if (ph == sdsh_pkg::P_WNEED)
        queue_request(sdsh_pkg::REQ_WDATA, 2'($urandom), $urandom, 8'($urandom),
                      8'($urandom));
      else
        queue_request(sdsh_pkg::REQ_BYTE, 2'($urandom), $urandom, card_reply(),
                      8'($urandom));
    end
  endtask

  // The block is idle once every request is taken and every result has arrived.
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      sdsh_pkg::R_INIT_RETRY: lim_retry = val[7:0];
      sdsh_pkg::R_RESP_POLL: lim_resp = val[7:0];
      sdsh_pkg::R_TOKEN_TO: lim_token = val;
      sdsh_pkg::R_BUSY_TO: lim_busy = val;
      default: extra_ms = val;
    endcase
  endtask

  // Random operations until the request total reaches stop_at.
  task automatic random_ops(int stop_at);
    logic [31:0] sec;
    while (generated < stop_at) begin
      case ($urandom_range(0, 3))
        0: sec = 32'hffff_ffff;
        1: sec = 32'd0;
        default: sec = $urandom;
      endcase
      if (ctype == sdsh_pkg::T_INVALID || $urandom_range(0, 9) == 0)
        run_op(sdsh_pkg::OP_INIT, sec, stop_at);
      else if ($urandom_range(0, 19) == 0) run_op(OP_UNUSED, sec, stop_at);
      else run_op($urandom_range(0, 1) ? sdsh_pkg::OP_READ : sdsh_pkg::OP_WRITE, sec,
                  stop_at);
    end
  endtask

  // Driver: offers the next pending request, idling at the chosen rate. A held
  // request stays on the bus until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_req.n > 0) owed_results.push_back(cur_req.r0);
        if (cur_req.n > 1) owed_results.push_back(cur_req.r1);
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_req.req;
          operation <= cur_req.op;
          sector_address <= cur_req.sector;
          miso_byte <= cur_req.miso;
          write_byte <= cur_req.wbyte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest owed one.
  always @(posedge clk) begin
    sdsh_pkg::res_t got;
    sdsh_pkg::res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{kind: out_kind, mosi: mosi_byte, cs_n: chip_select_n, fast: fast_clock,
                rd: read_byte, st: status, ty: card_type, lst: last};
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sd_card_spi_host_sequencer_top] ERROR");
      $finish;
    end
  end

  initial begin
    lim_retry = 8'd200;
    lim_resp = 8'd255;
    lim_token = 16'd20000;
    lim_busy = 16'd30000;
    extra_ms = 16'd1000;
    ph = sdsh_pkg::P_IDLE;
    bidx = 10'd0;
    polls = 16'd0;
    retries = 8'd0;
    ticks_left = 10'd0;
    frame = '0;
    r1_seen = 8'h80;
    ctype = sdsh_pkg::T_INVALID;
    hcap = 1'b0;
    fastm = 1'b0;
    baddr = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: stray requests, an unknown operation, a read before start-up
    // with the top sector, then start-up, a write and a read.
    queue_request(sdsh_pkg::REQ_TICK, sdsh_pkg::OP_INIT, 32'd0, 8'h00, 8'h00);
    queue_request(sdsh_pkg::REQ_BYTE, sdsh_pkg::OP_INIT, 32'd0, 8'hff, 8'h00);
    queue_request(sdsh_pkg::REQ_WDATA, sdsh_pkg::OP_INIT, 32'd0, 8'h00, 8'hff);
    run_op(OP_UNUSED, 32'd0, generated + 10);
    run_op(sdsh_pkg::OP_READ, 32'hffff_ffff, generated + 20);
    run_op(sdsh_pkg::OP_INIT, 32'd0, generated + 400);
    run_op(sdsh_pkg::OP_WRITE, 32'd0, generated + 30);
    run_op(sdsh_pkg::OP_READ, 32'h0000_0001, generated + 30);

    // First setting: defaults, sender rarely idle, receiver often stalled.
    random_ops(360);
    wait_quiet();

    // Second setting: lowest limits, zero limits acting as one, no extra busy wait.
    sender_idle_pct = 69;
    receiver_stall_pct = 15;
    write_reg(sdsh_pkg::R_INIT_RETRY, 16'd1);
    write_reg(sdsh_pkg::R_RESP_POLL, 16'd0);
    write_reg(sdsh_pkg::R_TOKEN_TO, 16'd1);
    write_reg(sdsh_pkg::R_BUSY_TO, 16'd0);
    write_reg(sdsh_pkg::R_BUSY_MS, 16'd0);
    random_ops(450);
    wait_quiet();

    // Short busy limit with a few extra milliseconds.
    write_reg(sdsh_pkg::R_INIT_RETRY, 16'd3);
    write_reg(sdsh_pkg::R_RESP_POLL, 16'd2);
    write_reg(sdsh_pkg::R_BUSY_TO, 16'd2);
    write_reg(sdsh_pkg::R_BUSY_MS, 16'd3);
    random_ops(530);
    wait_quiet();

    // Highest limits, no idling on either side.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_reg(sdsh_pkg::R_INIT_RETRY, 16'd255);
    write_reg(sdsh_pkg::R_RESP_POLL, 16'd255);
    write_reg(sdsh_pkg::R_TOKEN_TO, 16'hffff);
    write_reg(sdsh_pkg::R_BUSY_TO, 16'hffff);
    write_reg(sdsh_pkg::R_BUSY_MS, 16'hffff);
    random_ops(610);
    wait_quiet();

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("[sd_card_spi_host_sequencer_top] OK");
    end else begin
      $display("[sd_card_spi_host_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sdsh_pkg.sv
src/sd_card_spi_host_sequencer_top.sv
verif/sd_card_spi_host_sequencer_top_tb.sv
